// ===== hdl/ppau_pkg.sv =====
// shared constants, codes and types of the palette pixel alpha unpacker
package ppau_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int COLOR_W = 24;
  localparam int QUEUE_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  // item commands
  typedef enum logic {
    CMD_PAL_WRITE = 1'b0,
    CMD_PIXEL     = 1'b1
  } cmd_t;

  // alpha depth register codes
  localparam logic [3:0] ALPHA_NONE = 4'd0;
  localparam logic [3:0] ALPHA_1BIT = 4'd1;
  localparam logic [3:0] ALPHA_4BIT = 4'd4;
  localparam logic [3:0] ALPHA_8BIT = 4'd8;

  // one classified operation between front and back
  typedef struct packed {
    logic               pixel;
    logic [7:0]         addr;
    logic               in_range;
    logic [COLOR_W-1:0] color;
    logic [7:0]         alpha;
  } op_t;

endpackage

// ===== hdl/ppau_ifs.sv =====
// valid/ready channel interfaces for items, results and configuration
interface ppau_item_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  palette_slot;
  logic [23:0] palette_color;
  logic [7:0]  pixel_index;
  logic [7:0]  alpha_byte;
  logic        level_start;

  modport source (output valid, command, palette_slot, palette_color, pixel_index,
                  alpha_byte, level_start, input ready);
  modport sink (input valid, command, palette_slot, palette_color, pixel_index,
                alpha_byte, level_start, output ready);
endinterface

interface ppau_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] rgba;

  modport source (output valid, rgba, input ready);
  modport sink (input valid, rgba, output ready);
endinterface

interface ppau_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] alpha_bits;

  modport source (output valid, alpha_bits, input ready);
  modport sink (input valid, alpha_bits, output ready);
endinterface

// ===== hdl/ppau_ram.sv =====
// generic single-write, single-read memory with registered read data
module ppau_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]               wdata,
  input  logic                           re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ppau_front.sv =====
// front end: accepts items, holds the alpha register and sub-position, classifies ops
module ppau_front (
  input  logic           clk,
  input  logic           rst,
  ppau_cfg_if.sink       cfg,
  ppau_item_if.sink      items,
  output logic           push_valid,
  output ppau_pkg::op_t  push_op,
  input  logic           push_ready
);
  import ppau_pkg::*;

  logic [3:0] alpha_bits;
  logic [2:0] position;
  logic [2:0] position_next;
  logic [2:0] pos;
  logic [3:0] nib;
  logic [7:0] alpha;
  logic       is_pixel;

  assign cfg.ready   = 1'b1;
  assign items.ready = push_ready;
  assign push_valid  = items.valid;
  assign is_pixel    = (cmd_t'(items.command) == CMD_PIXEL);

  always_comb begin
    pos = items.level_start ? 3'd0 : position;
    position_next = pos;
    nib = pos[0] ? items.alpha_byte[7:4] : items.alpha_byte[3:0];
    unique case (alpha_bits)
      ALPHA_NONE: alpha = 8'hff;
      ALPHA_8BIT: alpha = items.alpha_byte;
      ALPHA_4BIT: begin
        alpha = {nib, nib};
        position_next = pos[0] ? 3'd0 : 3'd1;
      end
      ALPHA_1BIT: begin
        alpha = {8{items.alpha_byte[pos]}};
        position_next = pos + 3'd1;
      end
      default: alpha = 8'h00;
    endcase
  end

  always_comb begin
    push_op.pixel    = is_pixel;
    push_op.addr     = is_pixel ? items.pixel_index : items.palette_slot;
    push_op.in_range = ({1'b0, push_op.addr} < 9'(PALETTE_ENTRIES));
    push_op.color    = items.palette_color;
    push_op.alpha    = alpha;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_bits <= ALPHA_NONE;
      position   <= 3'd0;
    end else begin
      if (cfg.valid) begin
        alpha_bits <= cfg.alpha_bits;
      end
      if (items.valid && push_ready && is_pixel) begin
        position <= position_next;
      end
    end
  end

endmodule

// ===== hdl/ppau_queue.sv =====
// short op queue that decouples the front end from the back end
module ppau_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  ppau_pkg::op_t  push_op,
  output logic           push_ready,
  output logic           pop_valid,
  output ppau_pkg::op_t  pop_op,
  input  logic           pop_ready
);
  import ppau_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  op_t           slots [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = slots[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hdl/ppau_back.sv =====
// back end: palette writes and lookups, color swizzle and result buffer
module ppau_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  input  ppau_pkg::op_t  pop_op,
  output logic           pop_ready,
  ppau_result_if.source  results
);
  import ppau_pkg::*;

  localparam int OPW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  logic               take;
  logic               room;
  logic               s1_valid;
  logic               s1_in_range;
  logic [7:0]         s1_alpha;
  logic [COLOR_W-1:0] rdata;
  logic [COLOR_W-1:0] color;
  logic [31:0]        rgba_new;
  logic [31:0]        omem [OUT_DEPTH];
  logic [OPW-1:0]     owptr;
  logic [OPW-1:0]     orptr;
  logic [OCW-1:0]     ocount;
  logic               opop;

  // a lookup is issued only when the result buffer has a slot for it
  assign room      = ((OCW+1)'(ocount) + (OCW+1)'(s1_valid)) < (OCW+1)'(OUT_DEPTH);
  assign pop_ready = !pop_op.pixel || room;
  assign take      = pop_valid && pop_ready;

  ppau_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (take && !pop_op.pixel && pop_op.in_range),
    .waddr (pop_op.addr[PAL_AW-1:0]),
    .wdata (pop_op.color),
    .re    (take && pop_op.pixel),
    .raddr (pop_op.addr[PAL_AW-1:0]),
    .rdata (rdata)
  );

  // stored as blue/green/red low to high, sent as red/green/blue/alpha
  assign color    = s1_in_range ? rdata : '0;
  assign rgba_new = {s1_alpha, color[7:0], color[15:8], color[23:16]};

  assign results.valid = (ocount != '0);
  assign results.rgba  = omem[orptr];
  assign opop          = results.valid && results.ready;

  always_ff @(posedge clk) begin
    s1_alpha    <= pop_op.alpha;
    s1_in_range <= pop_op.in_range;
    if (s1_valid) begin
      omem[owptr] <= rgba_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      owptr    <= '0;
      orptr    <= '0;
      ocount   <= '0;
    end else begin
      s1_valid <= take && pop_op.pixel;
      if (s1_valid) begin
        owptr <= (owptr == OPW'(OUT_DEPTH - 1)) ? '0 : owptr + OPW'(1);
      end
      if (opop) begin
        orptr <= (orptr == OPW'(OUT_DEPTH - 1)) ? '0 : orptr + OPW'(1);
      end
      if (s1_valid && !opop) begin
        ocount <= ocount + OCW'(1);
      end else if (opop && !s1_valid) begin
        ocount <= ocount - OCW'(1);
      end
    end
  end

endmodule

// ===== hdl/palette_pixel_alpha_unpacker_unit.sv =====
// top level of the palette pixel alpha unpacker
// Decodes palettized texture pixels with a separate alpha plane. A palette
// write item (command 0) stores a 24-bit color in the 256-entry palette and
// gives no result; a pixel item (command 1) gives one rgba result: the palette
// color with red and blue swapped into RGBA order and an alpha taken from
// alpha_byte as the alpha_bits register selects (0: 255, 8: the byte, 4: a
// nibble times 0x11, low nibble first, 1: one bit as 0 or 255, other: 0).
// level_start on a pixel restarts the nibble/bit sub-position. The block
// takes one item per cycle, sustained, on both kinds of item, while the
// result side is not stalled; the single palette port does one write or
// one read per cycle and sets that figure. Items pass in order through a
// two-entry op queue, the palette memory read and a four-entry result
// buffer, so input and output stall independently. Write alpha_bits only
// while no pixel is in flight. Palette entries are undefined until written;
// do not read them before.
module palette_pixel_alpha_unpacker_unit (
  input  logic           clk,
  input  logic           rst,
  ppau_cfg_if.sink       cfg,
  ppau_item_if.sink      items,
  ppau_result_if.source  results
);
  import ppau_pkg::*;

  // front to queue
  logic push_valid;
  logic push_ready;
  op_t  push_op;

  // queue to back
  logic pop_valid;
  logic pop_ready;
  op_t  pop_op;

  // classification, alpha selection and sub-position tracking
  ppau_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .items      (items),
    .push_valid (push_valid),
    .push_op    (push_op),
    .push_ready (push_ready)
  );

  // decoupling queue, keeps item order for palette writes vs. lookups
  ppau_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_op    (push_op),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_op     (pop_op),
    .pop_ready  (pop_ready)
  );

  // palette memory, swizzle and result buffer
  ppau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_op    (pop_op),
    .pop_ready (pop_ready),
    .results   (results)
  );

endmodule

// ===== hdl/ppau_checker.sv =====
// port-level checker for the palette pixel alpha unpacker and its bind
module ppau_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_command,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_rgba,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [3:0]  cfg_alpha_bits
);
  import ppau_pkg::*;

  logic [3:0] alpha_bits;
  logic [2:0] pending;
  logic       pix_in;
  logic       res_out;

  assign pix_in  = in_valid && in_ready && (cmd_t'(in_command) == CMD_PIXEL);
  assign res_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_bits <= ALPHA_NONE;
      pending    <= 3'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        alpha_bits <= cfg_alpha_bits;
      end
      if (pix_in && !res_out) begin
        pending <= pending + 3'd1;
      end else if (res_out && !pix_in) begin
        pending <= pending - 3'd1;
      end
    end
  end

  // no result without a pixel transfer still owed one
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending != 3'd0))
    else $error("result offered with no pixel outstanding");

  // queue plus result buffer (memory stage counted against its room) bound the pixels in flight
  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'(QUEUE_DEPTH + OUT_DEPTH))
    else $error("more pixels in flight than the block can hold");

  // without an alpha plane every pixel is opaque
  a_opaque: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (alpha_bits == ALPHA_NONE)) |-> (out_rgba[31:24] == 8'hff))
    else $error("alpha not 255 with no alpha plane");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_rgba)))
    else $error("stalled result changed");

endmodule

bind palette_pixel_alpha_unpacker_unit ppau_checker u_ppau_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (items.valid),
  .in_ready       (items.ready),
  .in_command     (items.command),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .out_rgba       (results.rgba),
  .cfg_valid      (cfg.valid),
  .cfg_ready      (cfg.ready),
  .cfg_alpha_bits (cfg.alpha_bits)
);
